### sv/nacpu_pkg.sv
// Package for the nibble accumulator CPU step block.
// Opcode codes, field widths and the execute result struct; no dependencies.
package nacpu_pkg;

  localparam int INSTR_W  = 8;
  localparam int PC_W     = 8;
  localparam int NIB_W    = 4;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // instruction bit positions
  localparam int BRANCH_BIT = 7;
  localparam int IMM_BIT    = 6;
  localparam int STORE_BIT  = 3;
  localparam int SIGN_BIT   = 3;

  // upper nibble with the branch bit clear
  typedef enum logic [2:0] {
    OPC_ADD_REG  = 3'd0,
    OPC_NAND_REG = 3'd1,
    OPC_XOR_REG  = 3'd2,
    OPC_NOP      = 3'd3,
    OPC_ADD_IMM  = 3'd4,
    OPC_NAND_IMM = 3'd5,
    OPC_XOR_IMM  = 3'd6,
    OPC_MOVE     = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [PC_W-1:0]  next_pc;
    logic [NIB_W-1:0] acc;
    logic             reg_we;
  } exec_t;

endpackage

### sv/nacpu_if.sv
// Handshake channels of the nibble accumulator CPU step block.
// Depends on nacpu_pkg for field widths.
interface nacpu_in_if import nacpu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instruction;

  modport source(output valid, output instruction, input ready);
  modport sink(input valid, input instruction, output ready);
endinterface

interface nacpu_out_if import nacpu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PC_W-1:0]  next_pc;
  logic [NIB_W-1:0] accumulator;
  logic [NIB_W-1:0] out_port;

  modport source(output valid, output next_pc, output accumulator, output out_port,
                 input ready);
  modport sink(input valid, input next_pc, input accumulator, input out_port,
               output ready);
endinterface

### sv/nacpu_regfile.sv
// Eight-entry 4-bit register file, one write port, one indexed read port
// and a fixed tap on register 0. Depends on nacpu_pkg.
module nacpu_regfile import nacpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [REG_IDX_W-1:0] idx,
  input  logic [NIB_W-1:0]     wdata,
  output logic [NIB_W-1:0]     rdata,
  output logic [NIB_W-1:0]     reg0
);

  logic [NIB_W-1:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (we) begin
      regs_r[idx] <= wdata;
    end
  end

  assign rdata = regs_r[idx];
  assign reg0  = regs_r[0];

endmodule

### sv/nacpu_exec.sv
// Combinational execute step: next PC, accumulator and register write enable
// for one instruction. Depends on nacpu_pkg.
module nacpu_exec import nacpu_pkg::*; (
  input  logic [INSTR_W-1:0] instr,
  input  logic [PC_W-1:0]    pc,
  input  logic [NIB_W-1:0]   acc,
  input  logic [NIB_W-1:0]   reg_rdata,
  output exec_t              res
);

  opcode_t          opc;
  logic [NIB_W-1:0] opnd;
  logic [PC_W-1:0]  pc_inc;

  assign opc    = opcode_t'(instr[INSTR_W-2 -: 3]);
  assign opnd   = instr[IMM_BIT] ? instr[NIB_W-1:0] : reg_rdata;
  assign pc_inc = pc + PC_W'(1);

  always_comb begin
    res.next_pc = pc_inc;
    res.acc     = acc;
    res.reg_we  = 1'b0;
    if (instr[BRANCH_BIT]) begin
      if (acc[SIGN_BIT]) res.next_pc = {1'b0, instr[PC_W-2:0]};
    end else begin
      case (opc)
        OPC_ADD_REG, OPC_ADD_IMM:   res.acc = opnd + acc;
        OPC_NAND_REG, OPC_NAND_IMM: res.acc = ~(opnd & acc);
        OPC_XOR_REG, OPC_XOR_IMM:   res.acc = opnd ^ acc;
        OPC_MOVE: begin
          if (instr[STORE_BIT]) res.reg_we = 1'b1;
          else                  res.acc    = reg_rdata;
        end
        default: ;
      endcase
    end
  end

endmodule

### sv/nibble_accumulator_cpu_step.sv
// Nibble accumulator CPU step: executes one instruction word per input word.
// Input channel in_ch carries an 8-bit instruction fetched at the current PC.
// Output channel out_ch returns one word per instruction: the PC after it,
// the accumulator after it and register 0 (the output port) after it.
// Both channels use valid/ready; a word moves when both are high.
// An accepted instruction is held in the input register, is executed
// combinationally against the architectural state there, and its result
// lands in the output register once that register is free or being read.
// Throughput is one instruction per cycle while the receiver holds
// out_ch.ready high; the execute path runs from the input register through
// the register file read to the state and output registers.
// When the receiver stalls, the result waits in the output register and the
// next instruction waits in the input register; in_ch.ready drops only when
// both are occupied.
// Synchronous active-low reset clears PC, accumulator, all eight registers
// and both valid flags.
// Depends on nacpu_pkg, nacpu_if, nacpu_regfile and nacpu_exec.
module nibble_accumulator_cpu_step import nacpu_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  nacpu_in_if.sink      in_ch,
  nacpu_out_if.source   out_ch
);

  logic               ivalid_r;
  logic [INSTR_W-1:0] instr_r;
  logic [PC_W-1:0]    pc_r;
  logic [NIB_W-1:0]   acc_r;
  logic               ovalid_r;
  logic [PC_W-1:0]    opc_r;
  logic [NIB_W-1:0]   oacc_r;
  logic [NIB_W-1:0]   oport_r;

  logic               advance;
  logic               in_take;
  logic [NIB_W-1:0]   reg_rdata;
  logic [NIB_W-1:0]   reg0;
  logic [NIB_W-1:0]   reg0_nxt;
  exec_t              res;

  assign advance = ivalid_r && (!ovalid_r || out_ch.ready);
  assign in_ch.ready = !ivalid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  nacpu_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (advance && res.reg_we),
    .idx   (instr_r[REG_IDX_W-1:0]),
    .wdata (acc_r),
    .rdata (reg_rdata),
    .reg0  (reg0)
  );

  nacpu_exec u_exec (
    .instr     (instr_r),
    .pc        (pc_r),
    .acc       (acc_r),
    .reg_rdata (reg_rdata),
    .res       (res)
  );

  // store to register 0 shows on the port in the same result
  assign reg0_nxt = (res.reg_we && instr_r[REG_IDX_W-1:0] == '0) ? acc_r : reg0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
      ovalid_r <= 1'b0;
      pc_r     <= '0;
      acc_r    <= '0;
    end else begin
      if (in_take)      ivalid_r <= 1'b1;
      else if (advance) ivalid_r <= 1'b0;
      if (advance) begin
        ovalid_r <= 1'b1;
        pc_r     <= res.next_pc;
        acc_r    <= res.acc;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) instr_r <= in_ch.instruction;
    if (advance) begin
      opc_r   <= res.next_pc;
      oacc_r  <= res.acc;
      oport_r <= reg0_nxt;
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.next_pc     = opc_r;
  assign out_ch.accumulator = oacc_r;
  assign out_ch.out_port    = oport_r;

  a_adv_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.valid)
    else $error("executed word not presented");

  a_pc_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_ch.next_pc == pc_r && out_ch.accumulator == acc_r))
    else $error("output word disagrees with state");

  a_port_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.out_port == reg0)
    else $error("output port disagrees with register 0");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ivalid_r && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while both stages full");

endmodule

### bench/tb_nibble_accumulator_cpu_step.sv
// Regression bench for nibble_accumulator_cpu_step: drives instruction words and
// checks PC, accumulator and output port against an in-bench machine model.
// Depends on nacpu_pkg, nacpu_if and the block's RTL.
`timescale 1ns / 100ps

module tb_nibble_accumulator_cpu_step;
  import nacpu_pkg::*;

  typedef struct packed {
    logic [PC_W-1:0]  next_pc;
    logic [NIB_W-1:0] acc;
    logic [NIB_W-1:0] port;
  } cpu_view_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  nacpu_in_if  in_ch();
  nacpu_out_if out_ch();

  nibble_accumulator_cpu_step dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // machine state as the bench sees it
  logic [PC_W-1:0]  pc_model   = '0;
  logic [NIB_W-1:0] acc_model  = '0;
  logic [NIB_W-1:0] regs_model [NUM_REGS] = '{default: '0};

  cpu_view_t pending_views[$];
  int        n_bad    = 0;
  int        n_cycles = 0;
  bit        idle_on  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [INSTR_W-1:0] alu_word(opcode_t op, logic [NIB_W-1:0] low);
    return {1'b0, op, low};
  endfunction

  function automatic logic [INSTR_W-1:0] jump_word(logic [PC_W-2:0] target);
    return {1'b1, target};
  endfunction

  // executes one word against the model state, returns the visible state after it
  function automatic cpu_view_t execute_word(logic [INSTR_W-1:0] ins);
    logic [REG_IDX_W-1:0] sel;
    logic [NIB_W-1:0]     opnd;
    opcode_t              op;
    cpu_view_t            v;
    sel  = ins[REG_IDX_W-1:0];
    op   = opcode_t'(ins[6:4]);
    opnd = ins[IMM_BIT] ? ins[NIB_W-1:0] : regs_model[sel];
    if (ins[BRANCH_BIT]) begin
      if (acc_model[SIGN_BIT]) pc_model = {1'b0, ins[PC_W-2:0]};
      else pc_model = pc_model + 1'b1;
    end else begin
      case (op)
        OPC_ADD_REG, OPC_ADD_IMM:   acc_model = acc_model + opnd;
        OPC_NAND_REG, OPC_NAND_IMM: acc_model = ~(acc_model & opnd);
        OPC_XOR_REG, OPC_XOR_IMM:   acc_model = acc_model ^ opnd;
        OPC_MOVE: begin
          if (ins[STORE_BIT]) regs_model[sel] = acc_model;
          else acc_model = regs_model[sel];
        end
        default: ;
      endcase
      pc_model = pc_model + 1'b1;
    end
    v.next_pc = pc_model;
    v.acc     = acc_model;
    v.port    = regs_model[0];
    return v;
  endfunction

  // result check first, then prediction, so a word accepted this edge is never
  // matched against a result leaving this edge
  always @(posedge clk) begin : scoreboard
    cpu_view_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_views.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("unexpected result word: pc=%h acc=%h port=%h",
                     out_ch.next_pc, out_ch.accumulator, out_ch.out_port);
        end else begin
          want = pending_views.pop_front();
          if (want.next_pc !== out_ch.next_pc || want.acc !== out_ch.accumulator ||
              want.port !== out_ch.out_port) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
              $display("mismatch: expected pc=%h acc=%h port=%h, got pc=%h acc=%h port=%h",
                       want.next_pc, want.acc, want.port,
                       out_ch.next_pc, out_ch.accumulator, out_ch.out_port);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_views.push_back(execute_word(in_ch.instruction));
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("nibble_accumulator_cpu_step regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts while idling is on
  initial begin : receiver
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall = $urandom_range(1, 11) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one word, with an optional gap before it; returns at the accepting edge
  task automatic send_word(input logic [INSTR_W-1:0] ins);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.instruction <= ins;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [INSTR_W-1:0] prog [$];
    prog = '{
      alu_word(OPC_NAND_IMM, 4'h0), alu_word(OPC_MOVE, 4'h8), alu_word(OPC_MOVE, 4'hF),
      jump_word(7'h7F), jump_word(7'h00),
      alu_word(OPC_ADD_IMM, 4'hF), alu_word(OPC_NAND_IMM, 4'hF), jump_word(7'h55),
      alu_word(OPC_NOP, 4'h0), alu_word(OPC_NOP, 4'hF),
      alu_word(OPC_ADD_REG, 4'h7), alu_word(OPC_ADD_REG, 4'hF),  // bit 3 ignored
      alu_word(OPC_NAND_REG, 4'h8), alu_word(OPC_XOR_REG, 4'hA),
      alu_word(OPC_XOR_IMM, 4'hF), alu_word(OPC_MOVE, 4'hA), alu_word(OPC_XOR_REG, 4'h2),
      alu_word(OPC_MOVE, 4'h0), alu_word(OPC_XOR_IMM, 4'h5), alu_word(OPC_MOVE, 4'h8),
      alu_word(OPC_MOVE, 4'h7), alu_word(OPC_ADD_IMM, 4'h0), alu_word(OPC_NAND_REG, 4'h1)
    };
    foreach (prog[i]) send_word(prog[i]);
  endtask

  // force A[3], jump to the top of the branch range, then walk the PC past 255
  task automatic test_pc_wrap();
    send_word(alu_word(OPC_NAND_IMM, 4'h0));
    send_word(jump_word(7'h7F));
    repeat (132) send_word(INSTR_W'($urandom_range(0, 127)));
  endtask

  // sender holds off until every result is back, twice
  task automatic test_drain_pause();
    repeat (30) send_word(INSTR_W'($urandom_range(0, 255)));
    wait_drain();
    repeat (30) send_word(INSTR_W'($urandom_range(0, 255)));
    wait_drain();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_word(INSTR_W'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.instruction <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pc_wrap();
    test_drain_pause();
    test_random(1350);
    idle_on = 1'b0;
    test_random(250);

    wait_drain();
    repeat (6) @(posedge clk);
    if (n_bad == 0 && pending_views.size() == 0) begin
      $display("nibble_accumulator_cpu_step regression: pass");
    end else begin
      $display("nibble_accumulator_cpu_step regression: fail");
    end
    $finish;
  end

endmodule
